@@ rtl/core/semiprime_classifier_with_stats_assert.svh @@
// assertion macros for the semiprime classifier checker
// no dependencies
`ifndef SEMIPRIME_CLASSIFIER_WITH_STATS_ASSERT_SVH
`define SEMIPRIME_CLASSIFIER_WITH_STATS_ASSERT_SVH

// same-cycle implication
`define SPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spc assertion failed");

// next-cycle implication
`define SPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spc assertion failed");

`endif

@@ rtl/core/spc_pkg.sv @@
// shared types for the semiprime classifier
// no dependencies
package spc_pkg;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CHK  = 5'b00010,
        S_DIV  = 5'b00100,
        S_EVAL = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic next_d;
        logic phase_b;
        logic out_wr;
        logic hit;
    } t_dp_cmd;

    typedef struct packed {
        logic sq_gt;
        logic div_last;
        logic rem_zero;
    } t_dp_sts;

endpackage

@@ rtl/core/spc_if.sv @@
// request channel interfaces for the semiprime classifier
// depends on nothing
interface spc_in_if #(parameter int VALUE_BITS = 20);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface spc_out_if #(parameter int VALUE_BITS = 20, parameter int COUNT_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic                  is_semiprime;
    logic [COUNT_BITS-1:0] semiprime_count;
    logic [VALUE_BITS-1:0] largest;
    logic [VALUE_BITS-1:0] smallest;
    modport source (output valid, output is_semiprime, output semiprime_count,
                    output largest, output smallest, input ready);
    modport sink   (input valid, input is_semiprime, input semiprime_count,
                    input largest, input smallest, output ready);
endinterface

@@ rtl/core/semiprime_classifier_with_stats.sv @@
// semiprime classifier top level: one value in, flag plus running statistics out
// depends on spc_pkg, spc_in_if, spc_out_if, spc_ctrl, spc_datapath
// usage:
//   i_in carries one value per request, accepted when valid and ready are high.
//   o_out returns one result per request: the semiprime flag, the saturating
//   count of semiprimes so far, and the largest and smallest semiprime so far.
//   ready on i_in is high only while no value is being worked on.
//   the search tries divisors d = 2, 3, ... while d*d <= n; each trial is a
//   compare step, a bit-serial restoring division of the whole VALUE_BITS-bit
//   dividend and an evaluate step. after the smallest factor p is found, the
//   cofactor n/p is tested the same way starting from p. a value takes at most
//   about sqrt(2^VALUE_BITS) trials, all on the one shared divider.
//   a finished result sits in the output register; the next request is taken
//   while it waits, and its result is held back until the receiver takes it.
//   reset clears the control, the count and largest (0) and sets smallest to
//   all ones; no output is valid after reset.
module semiprime_classifier_with_stats #(
    parameter int VALUE_BITS = 20,
    parameter int COUNT_BITS = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    spc_in_if.sink     i_in,
    spc_out_if.source  o_out
);
    spc_pkg::t_dp_cmd cmd;
    spc_pkg::t_dp_sts sts;

    spc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    spc_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_value           (i_in.value),
        .o_is_semiprime    (o_out.is_semiprime),
        .o_semiprime_count (o_out.semiprime_count),
        .o_largest         (o_out.largest),
        .o_smallest        (o_out.smallest)
    );
endmodule

@@ rtl/core/spc_datapath.sv @@
// trial-division datapath, running statistics and result register
// depends on spc_pkg
module spc_datapath #(
    parameter int VALUE_BITS = 20,
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  spc_pkg::t_dp_cmd      i_cmd,
    output spc_pkg::t_dp_sts      o_sts,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_is_semiprime,
    output logic [COUNT_BITS-1:0] o_semiprime_count,
    output logic [VALUE_BITS-1:0] o_largest,
    output logic [VALUE_BITS-1:0] o_smallest
);
    localparam int DW   = VALUE_BITS / 2 + 1;
    localparam int CNTW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] r_target;
    logic [DW-1:0]         r_d;
    logic [DW-1:0]         r_rem, n_rem;
    logic [VALUE_BITS-1:0] r_dvd, n_dvd;
    logic [CNTW-1:0]       r_cnt;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [VALUE_BITS-1:0] r_large, n_large;
    logic [VALUE_BITS-1:0] r_small, n_small;
    logic                  r_o_hit;
    logic [COUNT_BITS-1:0] r_o_count;
    logic [VALUE_BITS-1:0] r_o_large;
    logic [VALUE_BITS-1:0] r_o_small;

    logic [2*DW-1:0] sq;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            ge;

    assign sq    = r_d * r_d;
    assign trial = {r_rem, r_dvd[VALUE_BITS-1]};
    assign ge    = trial >= {1'b0, r_d};
    assign diff  = trial - {1'b0, r_d};
    assign n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign n_dvd = {r_dvd[VALUE_BITS-2:0], ge};

    assign o_sts.sq_gt    = sq > {{(2*DW-VALUE_BITS){1'b0}}, r_target};
    assign o_sts.div_last = r_cnt == CNTW'(VALUE_BITS - 1);
    assign o_sts.rem_zero = r_rem == '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value  <= i_value;
            r_target <= i_value;
            r_d      <= DW'(2);
        end else begin
            if (i_cmd.phase_b) r_target <= r_dvd;
            if (i_cmd.next_d)  r_d      <= r_d + DW'(1);
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_dvd <= r_target;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_dvd <= n_dvd;
            r_cnt <= r_cnt + CNTW'(1);
        end
    end

    // running statistics
    always_comb begin
        n_count = r_count;
        n_large = r_large;
        n_small = r_small;
        if (i_cmd.hit) begin
            if (r_count != '1)      n_count = r_count + COUNT_BITS'(1);
            if (r_value > r_large)  n_large = r_value;
            if (r_value < r_small)  n_small = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_large <= '0;
            r_small <= '1;
        end else if (i_cmd.out_wr) begin
            r_count <= n_count;
            r_large <= n_large;
            r_small <= n_small;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_wr) begin
            r_o_hit   <= i_cmd.hit;
            r_o_count <= n_count;
            r_o_large <= n_large;
            r_o_small <= n_small;
        end
    end

    assign o_is_semiprime    = r_o_hit;
    assign o_semiprime_count = r_o_count;
    assign o_largest         = r_o_large;
    assign o_smallest        = r_o_small;
endmodule

@@ rtl/core/spc_ctrl.sv @@
// sequencer for the trial-division search and result handoff
// depends on spc_pkg
module spc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  spc_pkg::t_dp_sts i_sts,
    output spc_pkg::t_dp_cmd o_cmd
);
    spc_pkg::t_state r_state, n_state;
    logic r_phase_b, n_phase_b;
    logic r_hit, n_hit;
    logic r_out_valid;

    always_comb begin
        n_state    = r_state;
        n_phase_b  = r_phase_b;
        n_hit      = r_hit;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            spc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_phase_b  = 1'b0;
                    n_state    = spc_pkg::S_CHK;
                end
            end
            spc_pkg::S_CHK: begin
                if (i_sts.sq_gt) begin
                    // no divisor left: prime cofactor in phase b, no factor in phase a
                    n_hit   = r_phase_b;
                    n_state = spc_pkg::S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = spc_pkg::S_DIV;
                end
            end
            spc_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = spc_pkg::S_EVAL;
            end
            spc_pkg::S_EVAL: begin
                if (i_sts.rem_zero) begin
                    if (r_phase_b) begin
                        n_hit   = 1'b0;
                        n_state = spc_pkg::S_DONE;
                    end else begin
                        o_cmd.phase_b = 1'b1;
                        n_phase_b     = 1'b1;
                        n_state       = spc_pkg::S_CHK;
                    end
                end else begin
                    o_cmd.next_d = 1'b1;
                    n_state      = spc_pkg::S_CHK;
                end
            end
            spc_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_wr = 1'b1;
                    o_cmd.hit    = r_hit;
                    n_state      = spc_pkg::S_IDLE;
                end
            end
            default: n_state = spc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spc_pkg::S_IDLE;
            r_phase_b   <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase_b <= n_phase_b;
            r_hit     <= n_hit;
            if (o_cmd.out_wr)    r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

@@ rtl/core/spc_checker.sv @@
// port-level checker for the semiprime classifier, bound to the top level
// depends on semiprime_classifier_with_stats_assert.svh
`include "semiprime_classifier_with_stats_assert.svh"

module spc_checker #(
    parameter int VALUE_BITS = 20,
    parameter int COUNT_BITS = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic                  i_is_semiprime,
    input logic [COUNT_BITS-1:0] i_count,
    input logic [VALUE_BITS-1:0] i_largest,
    input logic [VALUE_BITS-1:0] i_smallest
);
    `SPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `SPC_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `SPC_ASSERT_NOW(a_hit_stats, i_clk, i_rst_n, i_out_valid && i_is_semiprime,
                    i_count != '0 && i_smallest <= i_largest)
    `SPC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready,
                     $stable(i_count) && $stable(i_largest) && $stable(i_smallest))
endmodule

bind semiprime_classifier_with_stats spc_checker #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
) u_spc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_is_semiprime (o_out.is_semiprime),
    .i_count        (o_out.semiprime_count),
    .i_largest      (o_out.largest),
    .i_smallest     (o_out.smallest)
);

@@ dv/testbench.sv @@
// testbench for the semiprime classifier: directed, back-pressure and random tests
// depends on spc_pkg, spc_in_if, spc_out_if and semiprime_classifier_with_stats
// results are predicted per request by trial division and checked in order
`timescale 1ns / 100ps
module testbench;
    localparam int VALUE_BITS = 20;
    localparam int COUNT_BITS = 16;

    typedef struct {
        logic                  is_semiprime;
        logic [COUNT_BITS-1:0] semiprime_count;
        logic [VALUE_BITS-1:0] largest;
        logic [VALUE_BITS-1:0] smallest;
    } t_stats;

    logic i_clk;
    logic i_rst_n;

    spc_in_if  #(.VALUE_BITS(VALUE_BITS)) in_if ();
    spc_out_if #(.VALUE_BITS(VALUE_BITS), .COUNT_BITS(COUNT_BITS)) out_if ();

    semiprime_classifier_with_stats #(
        .VALUE_BITS(VALUE_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    t_stats                pending_stats[$];
    int                    errors = 0;
    int                    send_idle = 0;
    int                    recv_stall = 0;
    int                    hold_cycles = 0;
    logic [COUNT_BITS-1:0] count_seen;
    logic [VALUE_BITS-1:0] largest_seen;
    logic [VALUE_BITS-1:0] smallest_seen;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic bit is_prime(int unsigned n);
        int unsigned d;
        if (n < 2) return 0;
        for (d = 2; d * d <= n; d++) begin
            if (n % d == 0) return 0;
        end
        return 1;
    endfunction

    function automatic bit is_semiprime_value(int unsigned n);
        int unsigned p;
        for (p = 2; p * p <= n; p++) begin
            if (is_prime(p) && (n % p == 0)) return is_prime(n / p);
        end
        return 0;
    endfunction

    function automatic t_stats classify(logic [VALUE_BITS-1:0] v);
        t_stats s;
        s.is_semiprime = is_semiprime_value(v);
        if (s.is_semiprime) begin
            if (count_seen != '1) count_seen = count_seen + 1'b1;
            if (v > largest_seen) largest_seen = v;
            if (v < smallest_seen) smallest_seen = v;
        end
        s.semiprime_count = count_seen;
        s.largest         = largest_seen;
        s.smallest        = smallest_seen;
        return s;
    endfunction

    // send one request, starting at a falling edge
    task automatic send_value(logic [VALUE_BITS-1:0] v);
        while ($urandom_range(99) < send_idle) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.value = v;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pending_stats.push_back(classify(v));
        @(negedge i_clk);
        in_if.valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_stats.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    // receiver side
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            out_if.ready = 1'b0;
        end else begin
            out_if.ready = ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        t_stats e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_stats.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                e = pending_stats.pop_front();
                if (out_if.is_semiprime !== e.is_semiprime) begin
                    $error("is_semiprime exp %0d got %0d", e.is_semiprime, out_if.is_semiprime);
                    errors++;
                end
                if (out_if.semiprime_count !== e.semiprime_count) begin
                    $error("semiprime_count exp %0d got %0d",
                           e.semiprime_count, out_if.semiprime_count);
                    errors++;
                end
                if (out_if.largest !== e.largest) begin
                    $error("largest exp %0d got %0d", e.largest, out_if.largest);
                    errors++;
                end
                if (out_if.smallest !== e.smallest) begin
                    $error("smallest exp %0d got %0d", e.smallest, out_if.smallest);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        logic [VALUE_BITS-1:0] vals[$];
        vals = '{0, 1, 2, 3, 4, 6, 8, 9, 12, 15, 25, 30, 49, 97, 121, 1048575,
                 1048574, 999983, 1042441, 65536, 4};
        foreach (vals[i]) send_value(vals[i]);
        drain();
    endtask

    task automatic test_backpressure();
        hold_cycles = 3000;
        repeat (6) send_value(VALUE_BITS'($urandom_range(255)));
        drain();
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 3) return VALUE_BITS'($urandom);
        if (sel < 45) return VALUE_BITS'($urandom_range(63, 2) * $urandom_range(63, 2));
        return VALUE_BITS'($urandom_range(4095));
    endfunction

    task automatic test_random();
        int idle_s[4] = '{0, 74, 0, 13};
        int idle_r[4] = '{0, 0, 74, 13};
        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = idle_s[ph];
            recv_stall = idle_r[ph];
            repeat (66) send_value(pick_value());
            if (ph == 1) drain();
        end
        send_idle  = 0;
        recv_stall = 0;
        drain();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.value     = '0;
        out_if.ready    = 1'b0;
        count_seen      = '0;
        largest_seen    = '0;
        smallest_seen   = '1;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #1000000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/spc_pkg.sv
rtl/core/spc_if.sv
rtl/core/spc_datapath.sv
rtl/core/spc_ctrl.sv
rtl/core/semiprime_classifier_with_stats.sv
rtl/core/spc_checker.sv
dv/testbench.sv
